// ===== sv/pppdf_pkg.sv =====
package pppdf_pkg;

	typedef enum logic [3:0] {
		PH_HUNT = 4'b0001,
		PH_HDR  = 4'b0010,
		PH_CTRL = 4'b0100,
		PH_BODY = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_FCS_BAD  = 2'd1,
		ST_SHORT    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
	localparam logic [7:0]  ESC_BYTE    = 8'h7D;
	localparam logic [7:0]  ESC_XOR     = 8'h20;
	localparam logic [7:0]  PROTO_BYTE  = 8'h21;
	localparam logic [7:0]  ADDR_BYTE   = 8'hFF;
	localparam logic [7:0]  CTRL_BYTE   = 8'h03;
	localparam logic [15:0] FCS_PRESET  = 16'hFFFF;
	localparam logic [15:0] FCS_AC_INIT = 16'h3DE3;
	localparam logic [15:0] FCS_POLY    = 16'h8408;
	localparam logic [15:0] FCS_RESIDUE = 16'hF0B8;
	localparam logic [9:0]  LEN_SAT     = 10'd1023;

	// Reflected CRC-16 (x^16 + x^12 + x^5 + 1), one octet, LSB first.
	function automatic logic [15:0] fcs16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ FCS_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/pppdf_in_if.sv =====
interface pppdf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

// ===== sv/pppdf_out_if.sv =====
interface pppdf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;
	logic [1:0] frame_status;
	logic [9:0] frame_length;

	modport source(output valid, output data_byte, output last, output frame_status,
		output frame_length, input ready);
	modport sink(input valid, input data_byte, input last, input frame_status,
		input frame_length, output ready);
endinterface

// ===== sv/ppp_hdlc_deframer_fcs16.sv =====
// Channel  Direction  Payload
// rx       in         rx_byte[7:0]: raw octet from the async line
// res      out        data_byte[7:0], last, frame_status[1:0], frame_length[9:0]
//
// One octet per cycle sustained while res is not stalled: a transfer on rx lands in an input
// register; from there it is destuffed, run through the byte-wide FCS and the frame FSM, and
// written into the result register, which drives res; octets that give no result vanish.
// The input stage advances whenever the result register is empty or being taken, so a
// stall on res backs up into rx.ready after one held octet.
// arst_n clears the FSM, escape flag, counters and both valid bits; no clearing pass.
module ppp_hdlc_deframer_fcs16 #(
	parameter int MAX_FRAME = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	pppdf_in_if.sink           rx,
	pppdf_out_if.source        res
);
	import pppdf_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME + 1);
	localparam int EXT_W = (CNT_W > 10) ? CNT_W : 10;

	// Input stage.
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;

	// Frame state.
	phase_t           phase_q, phase_n;
	logic             esc_q, esc_n;
	logic [15:0]      crc_q, crc_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             ovf_q, ovf_n;

	// Result register.
	logic             res_valid_q;
	logic [7:0]       res_data_q;
	logic             res_last_q;
	status_t          res_status_q;
	logic [9:0]       res_len_q;

	logic             r_valid;
	logic [7:0]       r_data;
	logic             r_last;
	status_t          r_status;
	logic [9:0]       r_len;

	logic [7:0]       b;
	logic             is_flag;
	logic             skip;
	logic             st_en;
	logic [15:0]      st_crc;
	logic [CNT_W-1:0] st_cnt;
	logic [EXT_W-1:0] cnt_ext;

	assign advance  = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	assign cnt_ext  = EXT_W'(cnt_q);

	always_comb begin
		phase_n  = phase_q;
		esc_n    = esc_q;
		crc_n    = crc_q;
		cnt_n    = cnt_q;
		ovf_n    = ovf_q;
		r_valid  = 1'b0;
		r_data   = 8'h00;
		r_last   = 1'b0;
		r_status = ST_GOOD;
		r_len    = 10'd0;
		b        = byte_s1;
		is_flag  = 1'b0;
		skip     = 1'b0;
		st_en    = 1'b0;
		st_crc   = crc_q;
		st_cnt   = cnt_q;

		if (esc_q) begin
			esc_n = 1'b0;
			b     = byte_s1 ^ ESC_XOR;
		end else if (byte_s1 == FLAG_BYTE) begin
			is_flag = 1'b1;
		end else if (byte_s1 == ESC_BYTE) begin
			esc_n = 1'b1;
			skip  = 1'b1;
		end

		if (is_flag) begin
			// A closing flag also opens the next frame.
			if (phase_q == PH_BODY && cnt_q != '0) begin
				r_valid = 1'b1;
				r_last  = 1'b1;
				r_len   = (cnt_ext > EXT_W'(LEN_SAT)) ? LEN_SAT : cnt_ext[9:0];
				priority if (ovf_q) begin
					r_status = ST_OVERFLOW;
				end else if (cnt_q < CNT_W'(2)) begin
					r_status = ST_SHORT;
				end else if (crc_q != FCS_RESIDUE) begin
					r_status = ST_FCS_BAD;
				end else begin
					r_status = ST_GOOD;
				end
			end
			phase_n = PH_HDR;
			cnt_n   = '0;
			ovf_n   = 1'b0;
		end else if (!skip) begin
			unique case (phase_q)
				PH_HUNT: begin
				end
				PH_HDR: begin
					if (b == PROTO_BYTE) begin
						phase_n = PH_BODY;
						ovf_n   = 1'b0;
						st_en   = 1'b1;
						st_crc  = FCS_PRESET;
						st_cnt  = '0;
					end else if (b == ADDR_BYTE) begin
						phase_n = PH_CTRL;
					end else begin
						phase_n = PH_HUNT;
					end
				end
				PH_CTRL: begin
					if (b == CTRL_BYTE) begin
						phase_n = PH_BODY;
						crc_n   = FCS_AC_INIT;
						cnt_n   = '0;
						ovf_n   = 1'b0;
					end else begin
						phase_n = PH_HUNT;
					end
				end
				PH_BODY: begin
					st_en = 1'b1;
				end
				default: begin
					phase_n = PH_HUNT;
				end
			endcase
		end

		if (st_en) begin
			if (st_cnt >= CNT_W'(MAX_FRAME)) begin
				ovf_n = 1'b1;
			end else begin
				cnt_n   = st_cnt + CNT_W'(1);
				crc_n   = fcs16_byte(st_crc, b);
				r_valid = 1'b1;
				r_data  = b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			esc_q   <= 1'b0;
			crc_q   <= FCS_PRESET;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_n;
			esc_q   <= esc_n;
			crc_q   <= crc_n;
			cnt_q   <= cnt_n;
			ovf_q   <= ovf_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= r_valid;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && r_valid) begin
			res_data_q   <= r_data;
			res_last_q   <= r_last;
			res_status_q <= r_status;
			res_len_q    <= r_len;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.data_byte    = res_data_q;
	assign res.last         = res_last_q;
	assign res.frame_status = res_status_q;
	assign res.frame_length = res_len_q;

endmodule
